[rtl/plti_pkg.sv]
// ----------------------------------------------------------------------------
// plti_pkg
// Shared widths, request codes and status codes of the piecewise linear
// trajectory interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int TIME_W = 32;
    localparam int VAL_W  = 24;
    localparam int LIM_W  = 23;
    localparam int MAG_W  = VAL_W;
    localparam int PROD_W = TIME_W + MAG_W;
    localparam int RES_W  = VAL_W + 2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = {LIM_W{1'b1}};

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

endpackage

[rtl/plti_mem.sv]
// ----------------------------------------------------------------------------
// plti_mem
// Breakpoint table: one write port and one registered read port holding
// the time and value of each breakpoint.
// ----------------------------------------------------------------------------
module plti_mem (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [plti_pkg::ADDR_W-1:0]       i_waddr,
    input  logic [plti_pkg::TIME_W-1:0]       i_wtime,
    input  logic signed [plti_pkg::VAL_W-1:0] i_wvalue,
    input  logic [plti_pkg::ADDR_W-1:0]       i_raddr,
    output logic [plti_pkg::TIME_W-1:0]       o_rtime,
    output logic signed [plti_pkg::VAL_W-1:0] o_rvalue
);
    import plti_pkg::*;

    logic [TIME_W-1:0]       r_times  [MAX_POINTS];
    logic signed [VAL_W-1:0] r_values [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_times[i_waddr]  <= i_wtime;
            r_values[i_waddr] <= i_wvalue;
        end
        o_rtime  <= r_times[i_raddr];
        o_rvalue <= r_values[i_raddr];
    end

endmodule

[rtl/plti_div.sv]
// ----------------------------------------------------------------------------
// plti_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in MAG_W bits (dividend < divisor << MAG_W).
// ----------------------------------------------------------------------------
module plti_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [plti_pkg::PROD_W-1:0]  i_dividend,
    input  logic [plti_pkg::TIME_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [plti_pkg::MAG_W-1:0]   o_quot
);
    import plti_pkg::*;

    localparam int STEP_W = $clog2(MAG_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_div;
    logic [MAG_W-1:0]  r_lo;
    logic [MAG_W-1:0]  r_quo;

    logic [TIME_W:0]   w_trial;
    logic              w_fit;

    // Bring down the next dividend bit and try a subtraction.
    assign w_trial = {r_rem, r_lo[MAG_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(MAG_W);
                r_rem  <= i_dividend[PROD_W-1:MAG_W];
                r_lo   <= i_dividend[MAG_W-1:0];
                r_div  <= i_divisor;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem  <= w_fit ? TIME_W'(w_trial - {1'b0, r_div}) : w_trial[TIME_W-1:0];
                r_lo   <= {r_lo[MAG_W-2:0], 1'b0};
                r_quo  <= {r_quo[MAG_W-2:0], w_fit};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[rtl/piecewise_linear_trajectory_interp_top.sv]
// Clear and append go from the accept straight to S_OUT, which registers the
// result beat once the result register is free. A query scans one breakpoint
// per cycle through the table read port; inside a segment it then runs S_MUL
// and the serial divider, then S_CLAMP and S_OUT. One item is in work at a
// time; the next request is taken the cycle after the result is registered.
// Reset (synchronous, active low) empties the table and sets the limit to max.
// ----------------------------------------------------------------------------
// piecewise_linear_trajectory_interp_top
// Breakpoint table with linear interpolation between the two breakpoints
// that bracket a query time, followed by a symmetric output clamp.
// ----------------------------------------------------------------------------
module piecewise_linear_trajectory_interp_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: output limit.
    input  logic                              i_cfg_we,
    input  logic [plti_pkg::LIM_W-1:0]        i_cfg_data,
    // Request channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_req_type,
    input  logic [plti_pkg::TIME_W-1:0]       i_point_time,
    input  logic signed [plti_pkg::VAL_W-1:0] i_point_value,
    input  logic [plti_pkg::TIME_W-1:0]       i_query_time,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [plti_pkg::VAL_W-1:0] o_result_value,
    output logic [1:0]                        o_status,
    output logic                              o_was_clamped
);
    import plti_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_CLAMP,
        S_OUT
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    logic [LIM_W-1:0]         r_limit;

    // Scan bookkeeping: r_iss is the address sent to the table, r_chk the
    // index whose data is currently on the read port.
    logic [CNT_W-1:0]         r_iss;
    logic [CNT_W-1:0]         r_chk;
    logic                     r_rd_vld;
    logic [TIME_W-1:0]        r_q;

    // Segment end points.
    logic [TIME_W-1:0]        r_t1;
    logic [TIME_W-1:0]        r_t2;
    logic signed [VAL_W-1:0]  r_u1;
    logic signed [VAL_W-1:0]  r_u2;

    logic [PROD_W-1:0]        r_prod;
    logic [TIME_W-1:0]        r_span;
    logic                     r_neg;
    logic                     r_div_start;

    logic signed [RES_W-1:0]  r_res;
    logic signed [VAL_W-1:0]  r_fin_value;
    logic [1:0]               r_fin_status;
    logic                     r_fin_clamped;

    logic                     r_out_vld;
    logic signed [VAL_W-1:0]  r_out_value;
    logic [1:0]               r_out_status;
    logic                     r_out_clamped;

    logic                     w_accept;
    logic                     w_we;
    logic [TIME_W-1:0]        w_rtime;
    logic signed [VAL_W-1:0]  w_rvalue;
    logic                     w_div_done;
    logic [MAG_W-1:0]         w_quot;

    logic signed [VAL_W:0]    w_du;
    logic [MAG_W-1:0]         w_mag;
    logic [TIME_W-1:0]        w_d;
    logic [PROD_W-1:0]        w_prod;
    logic signed [RES_W-1:0]  w_u1_ext;
    logic signed [RES_W-1:0]  w_quo_ext;
    logic signed [RES_W-1:0]  w_lim_pos;
    logic signed [RES_W-1:0]  w_lim_neg;
    logic                     w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Appends go straight into the table at the current fill count; a full
    // table drops the point.
    assign w_we = w_accept && (i_req_type == REQ_APPEND) && (r_count < CNT_W'(MAX_POINTS));

    plti_mem u_mem (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (r_count[ADDR_W-1:0]),
        .i_wtime  (i_point_time),
        .i_wvalue (i_point_value),
        .i_raddr  (r_iss[ADDR_W-1:0]),
        .o_rtime  (w_rtime),
        .o_rvalue (w_rvalue)
    );

    plti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Segment arithmetic. Within a selected segment q lies in (t1, t2], so
    // d * |du| / span never exceeds |du| and the quotient fits in MAG_W bits.
    assign w_du   = $signed({r_u2[VAL_W-1], r_u2}) - $signed({r_u1[VAL_W-1], r_u1});
    assign w_mag  = w_du[VAL_W] ? MAG_W'(-w_du) : w_du[MAG_W-1:0];
    assign w_d    = r_q - r_t1;
    assign w_prod = {{MAG_W{1'b0}}, w_d} * {{TIME_W{1'b0}}, w_mag};

    assign w_u1_ext  = RES_W'(r_u1);
    assign w_quo_ext = $signed({{(RES_W-MAG_W){1'b0}}, w_quot});
    assign w_lim_pos = $signed({{(RES_W-LIM_W){1'b0}}, r_limit});
    assign w_lim_neg = -w_lim_pos;

    // The result register frees up when empty or when its beat is taken.
    assign w_out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_rd_vld    <= 1'b0;
            r_div_start <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;

            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end

            if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_fin_value   <= '0;
                        r_fin_status  <= STAT_OK;
                        r_fin_clamped <= 1'b0;
                        r_state       <= S_OUT;
                        if (i_req_type == REQ_CLEAR) begin
                            r_count <= '0;
                        end else if (i_req_type == REQ_APPEND) begin
                            if (w_we) begin
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_fin_status <= STAT_FULL;
                            end
                        end else if (i_req_type == REQ_QUERY) begin
                            if (r_count == '0) begin
                                r_fin_status <= STAT_EMPTY;
                            end else begin
                                r_q      <= i_query_time;
                                r_iss    <= '0;
                                r_chk    <= '0;
                                r_rd_vld <= 1'b0;
                                r_state  <= S_SCAN;
                            end
                        end
                    end
                end

                S_SCAN: begin
                    // A new read goes out every cycle; the data of the
                    // previous read is checked against the query time.
                    r_iss    <= r_iss + 1'b1;
                    r_rd_vld <= 1'b1;
                    if (r_rd_vld) begin
                        if (w_rtime >= r_q) begin
                            if (r_chk == '0) begin
                                // Before the first breakpoint: hold its value.
                                r_res   <= RES_W'(w_rvalue);
                                r_state <= S_CLAMP;
                            end else begin
                                r_t2    <= w_rtime;
                                r_u2    <= w_rvalue;
                                r_state <= S_MUL;
                            end
                            r_rd_vld <= 1'b0;
                        end else if (r_chk + 1'b1 == r_count) begin
                            // Past the last breakpoint: hold its value.
                            r_res    <= RES_W'(w_rvalue);
                            r_state  <= S_CLAMP;
                            r_rd_vld <= 1'b0;
                        end else begin
                            r_t1  <= w_rtime;
                            r_u1  <= w_rvalue;
                            r_chk <= r_chk + 1'b1;
                        end
                    end
                end

                S_MUL: begin
                    if (r_t2 <= r_t1) begin
                        r_res   <= w_u1_ext;
                        r_state <= S_CLAMP;
                    end else begin
                        r_prod      <= w_prod;
                        r_span      <= r_t2 - r_t1;
                        r_neg       <= w_du[VAL_W];
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end

                S_DIV: begin
                    if (w_div_done) begin
                        r_res   <= r_neg ? (w_u1_ext - w_quo_ext) : (w_u1_ext + w_quo_ext);
                        r_state <= S_CLAMP;
                    end
                end

                S_CLAMP: begin
                    r_fin_status <= STAT_OK;
                    if (r_res > w_lim_pos) begin
                        r_fin_value   <= w_lim_pos[VAL_W-1:0];
                        r_fin_clamped <= 1'b1;
                    end else if (r_res < w_lim_neg) begin
                        r_fin_value   <= w_lim_neg[VAL_W-1:0];
                        r_fin_clamped <= 1'b1;
                    end else begin
                        r_fin_value   <= r_res[VAL_W-1:0];
                        r_fin_clamped <= 1'b0;
                    end
                    r_state <= S_OUT;
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_out_vld     <= 1'b1;
                        r_out_value   <= r_fin_value;
                        r_out_status  <= r_fin_status;
                        r_out_clamped <= r_fin_clamped;
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_was_clamped  = r_out_clamped;

endmodule

[dv/plti_result_checker.sv]
// ----------------------------------------------------------------------------
// plti_result_checker
// Watches the request, result and limit ports of the interpolator. It keeps
// its own breakpoint table and computes the expected result for every
// accepted request. Each result beat is compared field by field with the
// oldest expected result.
// ----------------------------------------------------------------------------
module plti_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [plti_pkg::LIM_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [1:0]                        i_req_type,
    input  logic [plti_pkg::TIME_W-1:0]       i_point_time,
    input  logic signed [plti_pkg::VAL_W-1:0] i_point_value,
    input  logic [plti_pkg::TIME_W-1:0]       i_query_time,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [plti_pkg::VAL_W-1:0] i_result_value,
    input  logic [1:0]                        i_status,
    input  logic                              i_was_clamped,
    output int                                o_pending,
    output int                                o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import plti_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
        logic                    clamped;
    } t_lookup_result;

    logic [TIME_W-1:0]       bp_time_mem  [MAX_POINTS];
    logic signed [VAL_W-1:0] bp_value_mem [MAX_POINTS];
    int                      bp_fill;
    logic [LIM_W-1:0]        clamp_limit;
    t_lookup_result          expected_results [$];
    int                      error_count;

    // Value on the segment from (t1, u1) to (t2, u2) at time q. The step
    // from u1 is truncated toward zero, so the result never leaves the range between u1 and u2.
    function automatic logic signed [63:0] segment_value(
        input logic [TIME_W-1:0] t1, input logic [TIME_W-1:0] t2,
        input logic signed [VAL_W-1:0] u1, input logic signed [VAL_W-1:0] u2,
        input logic [TIME_W-1:0] q);
        logic [63:0]        span;
        logic [63:0]        offset;
        logic [63:0]        mag;
        logic [63:0]        quo;
        logic signed [63:0] base;
        logic signed [63:0] du;
        base = 64'(u1);
        if (t2 <= t1) begin
            return base;
        end
        span   = 64'(t2) - 64'(t1);
        offset = 64'(q) - 64'(t1);
        du     = 64'(u2) - base;
        mag    = (du < 0) ? -du : du;
        quo    = (offset * mag) / span;
        return (du < 0) ? base - $signed(quo) : base + $signed(quo);
    endfunction

    // Applies one request to the local table and returns its result.
    function automatic t_lookup_result lookup_step(
        input logic [1:0] req, input logic [TIME_W-1:0] pt,
        input logic signed [VAL_W-1:0] pv, input logic [TIME_W-1:0] qt);
        t_lookup_result     res;
        int                 idx;
        logic signed [63:0] level;
        logic signed [63:0] lim;
        res = '0;
        case (req)
            REQ_CLEAR: begin
                bp_fill = 0;
            end
            REQ_APPEND: begin
                if (bp_fill >= MAX_POINTS) begin
                    res.status = STAT_FULL;
                end else begin
                    bp_time_mem[bp_fill]  = pt;
                    bp_value_mem[bp_fill] = pv;
                    bp_fill++;
                end
            end
            REQ_QUERY: begin
                if (bp_fill == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    idx = 0;
                    while (idx < bp_fill && bp_time_mem[idx] < qt) idx++;
                    if (idx == 0) begin
                        level = 64'(bp_value_mem[0]);
                    end else if (idx >= bp_fill) begin
                        level = 64'(bp_value_mem[bp_fill-1]);
                    end else begin
                        level = segment_value(bp_time_mem[idx-1], bp_time_mem[idx],
                                              bp_value_mem[idx-1], bp_value_mem[idx], qt);
                    end
                    lim = 64'(clamp_limit);
                    if (level > lim) begin
                        level       = lim;
                        res.clamped = 1'b1;
                    end else if (level < -lim) begin
                        level       = -lim;
                        res.clamped = 1'b1;
                    end
                    res.value = level[VAL_W-1:0];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            bp_fill     = 0;
            clamp_limit = LIMIT_RESET;
            error_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: result_value %0d status %0d was_clamped %0b",
                           i_result_value, i_status, i_was_clamped);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_result_value !== want.value) begin
                        $error("result_value: expected %0d, actual %0d",
                               $signed(want.value), i_result_value);
                        error_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        error_count++;
                    end
                    if (i_was_clamped !== want.clamped) begin
                        $error("was_clamped: expected %0b, actual %0b",
                               want.clamped, i_was_clamped);
                        error_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                clamp_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                want = lookup_step(i_req_type, i_point_time, i_point_value, i_query_time);
                expected_results.insert(expected_results.size(), want);
            end
        end
        o_pending <= expected_results.size();
        o_errors  <= error_count;
    end

endmodule

[dv/piecewise_linear_trajectory_interp_top_test.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_trajectory_interp_top_test
// Drives clear, append and query requests into the interpolator under random
// handshake gaps on both channels and changes the output limit between
// phases. A separate checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module piecewise_linear_trajectory_interp_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plti_pkg::*;

    // The request code that the block does not use. It must leave the table
    // alone and still return one all-zero result beat.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RUN_ITEMS    = 1100;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int TIMEOUT_NS   = 40_000_000;

    localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [TIME_W-1:0]       TIME_MAX = '1;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [LIM_W-1:0]        i_cfg_data     = '0;
    logic                    i_in_valid     = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_req_type     = REQ_CLEAR;
    logic [TIME_W-1:0]       i_point_time   = '0;
    logic signed [VAL_W-1:0] i_point_value  = '0;
    logic [TIME_W-1:0]       i_query_time   = '0;
    logic                    o_out_valid;
    logic                    i_out_ready    = 1'b0;
    logic signed [VAL_W-1:0] o_result_value;
    logic [1:0]              o_status;
    logic                    o_was_clamped;

    int pending;
    int error_total;
    int items_sent  = 0;
    bit sender_calm = 1'b0;

    piecewise_linear_trajectory_interp_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_point_time   (i_point_time),
        .i_point_value  (i_point_value),
        .i_query_time   (i_query_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_was_clamped  (o_was_clamped)
    );

    // The checker sits beside the block and sees exactly what the block sees.
    plti_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_point_time   (i_point_time),
        .i_point_value  (i_point_value),
        .i_query_time   (i_query_time),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_value (o_result_value),
        .i_status       (o_status),
        .i_was_clamped  (o_was_clamped),
        .o_pending      (pending),
        .o_errors       (error_total)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A hung handshake must not run forever.
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Idle cycles before a beat. Most gaps are short, a few are long, and in a
    // calm stretch there are none at all.
    function automatic int pick_gap(input bit calm);
        int roll;
        if (calm) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offers one request beat and returns in the time step of its acceptance.
    // Valid is only lowered when a gap follows, so back-to-back beats keep it
    // high without a glitch.
    task automatic send_beat(input logic [1:0] req, input logic [TIME_W-1:0] pt,
                             input logic signed [VAL_W-1:0] pv,
                             input logic [TIME_W-1:0] qt);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_point_time  <= pt;
        i_point_value <= pv;
        i_query_time  <= qt;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Every request gives exactly one result beat, so once nothing is
    // pending the block has finished its work.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] lim);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Result side. Ready drops for random gaps, with calm stretches in
    // between. From beat 150 on, every 600 beats it holds off for a long stretch so that the
    // block fills up and has to stall the request channel.
    initial begin : result_sink
        int hold;
        int beats;
        int stretch;
        int next_long;
        bit calm;
        hold      = 0;
        beats     = 0;
        stretch   = 0;
        next_long = 150;
        calm      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                beats++;
            end
            if (stretch == 0) begin
                calm    = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(50, 200);
            end else begin
                stretch--;
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
                if (beats >= next_long) begin
                    hold      = LONG_HOLD;
                    next_long = next_long + 600;
                end else begin
                    hold = pick_gap(calm);
                end
            end
        end
    end

    initial begin : stimulus
        logic [LIM_W-1:0]  lim;
        logic [TIME_W-1:0] pt_log [80];
        logic [TIME_W-1:0] t_cur;
        logic [TIME_W-1:0] t_first;
        logic [TIME_W-1:0] t_last;
        logic [TIME_W-1:0] q;
        int                n_pts;
        int                step_max;
        int                roll;
        bit                shuffled;
        bit                force_full;

        force_full = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A query on an empty table comes first, then the unused
        // request with every field at an extreme.
        send_beat(REQ_QUERY, '0, '0, 32'd5);
        send_beat(REQ_UNUSED, TIME_MAX, VAL_MIN, TIME_MAX);

        // A table that spans the full time range and the full value range,
        // with a repeated time in the middle.
        send_beat(REQ_APPEND, 32'd0, VAL_MIN, TIME_MAX);
        send_beat(REQ_APPEND, 32'd1000, VAL_MAX, '0);
        send_beat(REQ_APPEND, 32'd1000, 24'sd5, '0);
        send_beat(REQ_APPEND, 32'd4000, -24'sd3, '0);
        send_beat(REQ_APPEND, TIME_MAX, VAL_MAX, '0);

        // The most negative value lies beyond the reset limit and is clamped.
        send_beat(REQ_QUERY, '0, '0, 32'd0);
        // Steep rise, then the exact breakpoint time.
        send_beat(REQ_QUERY, '0, '0, 32'd1);
        send_beat(REQ_QUERY, '0, '0, 32'd999);
        send_beat(REQ_QUERY, '0, '0, 32'd1000);
        // A falling segment where the step is truncated toward zero.
        send_beat(REQ_QUERY, '0, '0, 32'd1001);
        send_beat(REQ_QUERY, '0, '0, 32'd2500);
        // The last segment spans nearly the whole time range.
        send_beat(REQ_QUERY, '0, '0, 32'd4001);
        send_beat(REQ_QUERY, '0, '0, TIME_MAX);

        // Clear, a query on the empty table, then queries before the first and after the last point.
        send_beat(REQ_CLEAR, TIME_MAX, VAL_MAX, TIME_MAX);
        send_beat(REQ_QUERY, '0, '0, 32'd7);
        send_beat(REQ_APPEND, 32'd500, -24'sd7, '0);
        send_beat(REQ_QUERY, '0, '0, 32'd0);
        send_beat(REQ_QUERY, '0, '0, 32'd600);

        // A point appended out of order. The scan takes the first time that
        // is not below the query.
        send_beat(REQ_APPEND, 32'd100, 24'sd20, '0);
        send_beat(REQ_QUERY, '0, '0, 32'd501);
        send_beat(REQ_QUERY, '0, '0, 32'd300);

        // A zero limit clamps every nonzero result.
        write_limit('0);
        send_beat(REQ_QUERY, '0, '0, 32'd501);

        // Random part, in phases. Each phase starts from an idle block with a
        // new output limit.
        while (items_sent < RUN_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       lim = '0;
                1:       lim = LIMIT_RESET;
                2:       lim = LIM_W'($urandom_range(1, 255));
                3:       lim = LIM_W'($urandom_range(4096, 1 << 20));
                default: lim = LIM_W'($urandom);
            endcase
            write_limit(lim);

            repeat ($urandom_range(1, 4)) begin
                sender_calm = ($urandom_range(0, 4) == 0);
                if (force_full || $urandom_range(0, 99) < 80) begin
                    // Well-formed sequence: clear, a run of mostly ascending points,
                    // then queries mostly inside the loaded time range. A few
                    // sequences overrun the table to see points dropped.
                    send_beat(REQ_CLEAR, $urandom, VAL_W'($urandom), $urandom);
                    if (force_full || $urandom_range(0, 99) < 8) begin
                        n_pts = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 6);
                    end else begin
                        n_pts = $urandom_range(1, 10);
                    end
                    force_full = 1'b0;
                    case ($urandom_range(0, 3))
                        0:       step_max = 10;
                        1:       step_max = 1000;
                        2:       step_max = 1 << 20;
                        default: step_max = 1 << 28;
                    endcase
                    t_cur    = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000);
                    shuffled = ($urandom_range(0, 9) == 0);
                    for (int k = 0; k < n_pts; k++) begin
                        pt_log[k] = t_cur;
                        send_beat(REQ_APPEND, t_cur, VAL_W'($urandom), $urandom);
                        if (shuffled && $urandom_range(0, 2) == 0) begin
                            t_cur = $urandom;
                        end else if ($urandom_range(0, 5) == 0) begin
                            t_cur = t_cur + $urandom_range(0, 2);
                        end else begin
                            t_cur = t_cur + $urandom_range(1, step_max);
                        end
                    end
                    if (n_pts > MAX_POINTS) begin
                        n_pts = MAX_POINTS;
                    end
                    t_first = pt_log[0];
                    t_last  = pt_log[n_pts-1];
                    repeat ($urandom_range(3, 10)) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 55 && t_last >= t_first) begin
                            q = t_first + $urandom_range(0, t_last - t_first);
                        end else if (roll < 75) begin
                            q = pt_log[$urandom_range(0, n_pts - 1)];
                        end else if (roll < 85) begin
                            q = t_first - $urandom_range(0, 5);
                        end else if (roll < 92) begin
                            q = t_last + $urandom_range(0, 5);
                        end else begin
                            q = $urandom;
                        end
                        send_beat(REQ_QUERY, $urandom, VAL_W'($urandom), q);
                    end
                end else begin
                    // Noise: any request code with every field random.
                    repeat ($urandom_range(5, 15)) begin
                        send_beat(2'($urandom_range(0, 3)), $urandom,
                                  VAL_W'($urandom), $urandom);
                    end
                end
            end
        end

        // Let the last results come out, then give the block time to show
        // any stray beat.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_total == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
